>>> src/frp_pkg.sv
// Shared types and constants for the first-order rational projection block.
package frp_pkg;

    // Command codes carried in each input transaction.
    localparam logic CMD_POINT = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_SAT      = 2'd2;

    // Parameter table layout.
    localparam int TABLE_DEPTH    = 24;
    localparam int IDX_COL_BASE   = 0;
    localparam int IDX_ROW_BASE   = 7;
    localparam int IDX_SRC_CENTRE = 14;
    localparam int IDX_DST_CENTRE = 17;
    localparam int IDX_SRC_RSCALE = 19;
    localparam int IDX_DST_SCALE  = 22;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic               command;
        logic [4:0]         table_index;
        logic signed [31:0] table_value;
        logic signed [31:0] src_x;
        logic signed [31:0] src_y;
        logic signed [31:0] src_z;
        logic signed [31:0] obs_x;
        logic signed [31:0] obs_y;
        logic               last_in;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] proj_x;
        logic signed [31:0] proj_y;
        logic signed [31:0] resid_x;
        logic signed [31:0] resid_y;
        logic [1:0]         status;
        logic               last_out;
    } t_out_item;

    // Sideband that travels with a point down the pipeline and divider cells.
    typedef struct packed {
        logic               valid;
        logic               last;
        logic               zero;
        logic               sat;
        logic [1:0]         neg;
        logic signed [31:0] obs_x;
        logic signed [31:0] obs_y;
    } t_cell_ctl;

endpackage

>>> src/frp_in_if.sv
// Valid/ready channel that carries input transactions.
interface frp_in_if;
    logic              valid;
    logic              ready;
    frp_pkg::t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> src/frp_out_if.sv
// Valid/ready channel that carries result transactions.
interface frp_out_if;
    logic               valid;
    logic               ready;
    frp_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> src/frp_div_cell.sv
// One cell of the divider chain: produces one quotient bit for both image axes.
module frp_div_cell #(
    parameter int DW = 48
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  frp_pkg::t_cell_ctl      i_ctl,
    input  logic [1:0][31:0]        i_div,
    input  logic [1:0][31:0]        i_rem,
    input  logic [1:0][DW-1:0]      i_work,
    output frp_pkg::t_cell_ctl      o_ctl,
    output logic [1:0][31:0]        o_div,
    output logic [1:0][31:0]        o_rem,
    output logic [1:0][DW-1:0]      o_work
);
    import frp_pkg::*;

    t_cell_ctl         r_ctl;
    logic [1:0][31:0]  r_div;
    logic [1:0][31:0]  r_rem;
    logic [1:0][DW-1:0] r_work;
    logic [1:0][31:0]  n_rem;
    logic [1:0][DW-1:0] n_work;

    // Restoring step: bring down the next dividend bit and try a subtract.
    always_comb begin
        logic [32:0] trial;
        logic        ge;
        for (int a = 0; a < 2; a++) begin
            trial     = {i_rem[a], i_work[a][DW-1]};
            ge        = trial >= {1'b0, i_div[a]};
            n_rem[a]  = ge ? 32'(trial - {1'b0, i_div[a]}) : trial[31:0];
            n_work[a] = {i_work[a][DW-2:0], ge};
        end
    end

    // Sideband register, cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div  <= i_div;
            r_rem  <= n_rem;
            r_work <= n_work;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_div  = r_div;
    assign o_rem  = r_rem;
    assign o_work = r_work;
endmodule

>>> src/first_order_rational_projection.sv
// Top level of the first-order rational projection pipeline.
//
// Input channel i_pt carries two kinds of transaction. A write transaction
// stores table_value into parameter table slot table_index (slots above 23
// are ignored) and produces no result. A point transaction normalizes the
// source point, forms the column and row ratios and returns one result on
// o_res with the projected point, the residuals, a status and last_out.
// Table words must be written before a point reads them.
//
// A point passes four arithmetic stages, one divider cell per quotient bit
// (32 + COORD_FRAC_BITS cells), a scaling multiply and the output register.
// One point is taken every cycle unless the output stalls. A write
// transaction waits until every point in flight has passed the last stage
// that reads the table.
//
// Reset empties the pipeline; the table contents are kept undefined until
// written. When the receiver holds o_res.ready low with a result waiting,
// the whole pipeline holds and i_pt.ready falls until the result is taken.
module first_order_rational_projection #(
    parameter int COORD_FRAC_BITS = 16,
    parameter int COEF_FRAC_BITS  = 30
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    frp_in_if.sink      i_pt,
    frp_out_if.source   o_res
);
    import frp_pkg::*;

    localparam int CO  = COORD_FRAC_BITS;
    localparam int CF  = COEF_FRAC_BITS;
    localparam int DW  = 32 + CO;
    localparam int PW  = 65 - CO;
    localparam int TW  = 64 - CF;
    localparam int SW  = TW + 2;
    localparam int SHR = (CF >= CO) ? (CF - CO) : 0;
    localparam int SHL = (CF >= CO) ? 0 : (CO - CF);
    localparam int MW  = 64 - CO;
    localparam int AW  = MW + 2;
    localparam logic signed [SW-1:0] DEN_ONE = SW'(1) << CO;

    logic [31:0] r_tab [TABLE_DEPTH];

    logic        en;
    logic        busy;
    logic        accept;
    logic        pt_go;

    t_cell_ctl   r0_ctl, r1_ctl, r2_ctl, r3_ctl, r5_ctl;
    logic signed [32:0] r0_d [3];
    logic signed [31:0] r1_nrm [3];
    logic signed [TW-1:0] r2_nt [2][3];
    logic signed [TW-1:0] r2_dt [2][3];
    logic signed [31:0] r3_num [2];
    logic signed [31:0] r3_den [2];
    logic signed [MW-1:0] r5_p [2];

    logic signed [31:0] n1_nrm [3];
    logic               n1_sat;
    logic signed [TW-1:0] n2_nt [2][3];
    logic signed [TW-1:0] n2_dt [2][3];
    logic signed [31:0] n3_num [2];
    logic signed [31:0] n3_den [2];
    logic               n3_sat;
    logic               n3_zero;
    logic signed [31:0] n5_q [2];
    logic               n5_sat;
    logic signed [MW-1:0] n5_p [2];

    t_cell_ctl          c_ctl  [DW+1];
    logic [1:0][31:0]   c_div  [DW+1];
    logic [1:0][31:0]   c_rem  [DW+1];
    logic [1:0][DW-1:0] c_work [DW+1];

    t_out_item r_out;
    t_out_item n_out;
    logic      r_out_valid;

    // Global advance: the pipeline moves whenever the output slot is free.
    assign en     = !r_out_valid || o_res.ready;
    assign accept = i_pt.valid && i_pt.ready;
    assign pt_go  = accept && (i_pt.payload.command == CMD_POINT);

    // Any point still reading the table blocks a table write.
    always_comb begin
        busy = r0_ctl.valid || r1_ctl.valid || r2_ctl.valid || r3_ctl.valid
            || r5_ctl.valid;
        for (int c = 1; c <= DW; c++) begin
            busy = busy || c_ctl[c].valid;
        end
    end

    assign i_pt.ready = en && !(i_pt.valid && (i_pt.payload.command == CMD_WRITE) && busy);

    // Parameter table write.
    always_ff @(posedge i_clk) begin
        if (accept && (i_pt.payload.command == CMD_WRITE)
                && (i_pt.payload.table_index < 5'(TABLE_DEPTH))) begin
            r_tab[i_pt.payload.table_index] <= i_pt.payload.table_value;
        end
    end

    // Stage 0: subtract the source centres.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_ctl <= '0;
        end else if (en) begin
            r0_ctl.valid <= pt_go;
            r0_ctl.last  <= i_pt.payload.last_in;
            r0_ctl.zero  <= 1'b0;
            r0_ctl.sat   <= 1'b0;
            r0_ctl.neg   <= '0;
            r0_ctl.obs_x <= i_pt.payload.obs_x;
            r0_ctl.obs_y <= i_pt.payload.obs_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_d[0] <= 33'(i_pt.payload.src_x) - 33'($signed(r_tab[IDX_SRC_CENTRE]));
            r0_d[1] <= 33'(i_pt.payload.src_y) - 33'($signed(r_tab[IDX_SRC_CENTRE + 1]));
            r0_d[2] <= 33'(i_pt.payload.src_z) - 33'($signed(r_tab[IDX_SRC_CENTRE + 2]));
        end
    end

    // Stage 1: scale by the reciprocal source scales and saturate.
    always_comb begin
        logic signed [64:0]   prod;
        logic signed [PW-1:0] sh;
        logic                 fits;
        n1_sat = r0_ctl.sat;
        for (int i = 0; i < 3; i++) begin
            prod = r0_d[i] * $signed(r_tab[IDX_SRC_RSCALE + i]);
            sh   = prod[64:CO];
            fits = (&sh[PW-1:31]) || !(|sh[PW-1:31]);
            n1_nrm[i] = fits ? sh[31:0] : (sh[PW-1] ? Q_MIN : Q_MAX);
            n1_sat    = n1_sat || !fits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
        end else if (en) begin
            r1_ctl     <= r0_ctl;
            r1_ctl.sat <= n1_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_nrm <= n1_nrm;
        end
    end

    // Stage 2: coefficient products for both numerators and denominators.
    always_comb begin
        logic signed [63:0] pn;
        logic signed [63:0] pd;
        int                 base;
        for (int a = 0; a < 2; a++) begin
            base = (a == 0) ? IDX_COL_BASE : IDX_ROW_BASE;
            for (int i = 0; i < 3; i++) begin
                pn = $signed(r_tab[base + i]) * r1_nrm[i];
                pd = $signed(r_tab[base + 4 + i]) * r1_nrm[i];
                n2_nt[a][i] = pn[63:CF];
                n2_dt[a][i] = pd[63:CF];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0;
        end else if (en) begin
            r2_ctl <= r1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_nt <= n2_nt;
            r2_dt <= n2_dt;
        end
    end

    // Stage 3: sum the terms, saturate and flag a zero denominator.
    always_comb begin
        logic signed [SW-1:0] num;
        logic signed [SW-1:0] den;
        logic                 fn;
        logic                 fd;
        int                   base;
        n3_sat  = r2_ctl.sat;
        n3_zero = 1'b0;
        for (int a = 0; a < 2; a++) begin
            base = (a == 0) ? IDX_COL_BASE : IDX_ROW_BASE;
            num  = (SW'($signed(r_tab[base + 3])) >>> SHR) <<< SHL;
            den  = DEN_ONE;
            for (int i = 0; i < 3; i++) begin
                num = num + SW'(r2_nt[a][i]);
                den = den + SW'(r2_dt[a][i]);
            end
            fn = (&num[SW-1:31]) || !(|num[SW-1:31]);
            fd = (&den[SW-1:31]) || !(|den[SW-1:31]);
            n3_num[a] = fn ? num[31:0] : (num[SW-1] ? Q_MIN : Q_MAX);
            n3_den[a] = fd ? den[31:0] : (den[SW-1] ? Q_MIN : Q_MAX);
            n3_sat    = n3_sat || !fn || !fd;
            n3_zero   = n3_zero || (n3_den[a] == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctl <= '0;
        end else if (en) begin
            r3_ctl      <= r2_ctl;
            r3_ctl.sat  <= n3_sat;
            r3_ctl.zero <= n3_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_num <= n3_num;
            r3_den <= n3_den;
        end
    end

    // Divider entry: magnitudes, result sign and scaled dividend.
    always_comb begin
        logic [31:0] nm;
        c_ctl[0] = r3_ctl;
        for (int a = 0; a < 2; a++) begin
            nm = r3_num[a][31] ? 32'(-r3_num[a]) : r3_num[a];
            c_ctl[0].neg[a] = r3_num[a][31] ^ r3_den[a][31];
            c_div[0][a]     = r3_den[a][31] ? 32'(-r3_den[a]) : r3_den[a];
            c_rem[0][a]     = '0;
            c_work[0][a]    = {nm, {CO{1'b0}}};
        end
    end

    // Divider chain: one quotient bit per cell.
    for (genvar c = 0; c < DW; c++) begin : g_cell
        frp_div_cell #(.DW(DW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (c_ctl[c]),
            .i_div   (c_div[c]),
            .i_rem   (c_rem[c]),
            .i_work  (c_work[c]),
            .o_ctl   (c_ctl[c+1]),
            .o_div   (c_div[c+1]),
            .o_rem   (c_rem[c+1]),
            .o_work  (c_work[c+1])
        );
    end

    // Stage 5: sign and saturate the quotient, multiply by the destination scale.
    always_comb begin
        logic [DW-1:0]      qm;
        logic               hz;
        logic               is_min;
        logic               qs;
        logic signed [63:0] prod;
        n5_sat = c_ctl[DW].sat;
        for (int a = 0; a < 2; a++) begin
            qm     = c_work[DW][a];
            hz     = !(|qm[DW-1:31]);
            is_min = qm == (DW'(1) << 31);
            if (c_ctl[DW].neg[a]) begin
                qs      = !hz && !is_min;
                n5_q[a] = qs ? Q_MIN : 32'(-qm[31:0]);
            end else begin
                qs      = !hz;
                n5_q[a] = qs ? Q_MAX : qm[31:0];
            end
            n5_sat  = n5_sat || qs;
            prod    = $signed(r_tab[IDX_DST_SCALE + a]) * n5_q[a];
            n5_p[a] = prod[63:CO];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_ctl <= '0;
        end else if (en) begin
            r5_ctl     <= c_ctl[DW];
            r5_ctl.sat <= n5_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_p <= n5_p;
        end
    end

    // Output stage: add the destination centre, form residuals and status.
    always_comb begin
        logic signed [AW-1:0] p;
        logic signed [AW-1:0] r;
        logic signed [31:0]   pv [2];
        logic signed [31:0]   rv [2];
        logic                 fp;
        logic                 fr;
        logic                 sat;
        sat = r5_ctl.sat;
        for (int a = 0; a < 2; a++) begin
            p  = AW'($signed(r_tab[IDX_DST_CENTRE + a])) + AW'(r5_p[a]);
            r  = AW'((a == 0) ? r5_ctl.obs_x : r5_ctl.obs_y) - p;
            fp = (&p[AW-1:31]) || !(|p[AW-1:31]);
            fr = (&r[AW-1:31]) || !(|r[AW-1:31]);
            pv[a] = fp ? p[31:0] : (p[AW-1] ? Q_MIN : Q_MAX);
            rv[a] = fr ? r[31:0] : (r[AW-1] ? Q_MIN : Q_MAX);
            sat   = sat || !fp || !fr;
        end
        n_out.last_out = r5_ctl.last;
        if (r5_ctl.zero) begin
            n_out.proj_x  = '0;
            n_out.proj_y  = '0;
            n_out.resid_x = '0;
            n_out.resid_y = '0;
            n_out.status  = ST_ZERO_DEN;
        end else begin
            n_out.proj_x  = pv[0];
            n_out.proj_y  = pv[1];
            n_out.resid_x = rv[0];
            n_out.resid_y = rv[1];
            n_out.status  = sat ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r5_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

    // A table write never overtakes a point that still reads the table.
    a_write_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_pt.payload.command == CMD_WRITE)) |-> !busy)
        else $error("table write accepted while points in flight");

    // A zero denominator clears every coordinate of the result.
    a_zero_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.payload.status == ST_ZERO_DEN)) |->
        (o_res.payload.proj_x == '0 && o_res.payload.proj_y == '0
         && o_res.payload.resid_x == '0 && o_res.payload.resid_y == '0))
        else $error("zero-denominator result carries nonzero coordinates");

    // Status always holds a defined code.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.payload.status == ST_OK
                         || o_res.payload.status == ST_ZERO_DEN
                         || o_res.payload.status == ST_SAT))
        else $error("undefined status code");

    // The pipeline comes out of reset empty.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!o_res.valid && !busy))
        else $error("pipeline not empty after reset");

endmodule
